// File: design/postfix_stack_evaluator_top_macros.svh
// assertion macros shared by the checker of the postfix stack evaluator
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH

// plain property checked on every clock edge outside reset
`define PSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal holds while a transfer is stalled
`define PSE_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// File: design/pse_pkg.sv
// shared types and constants of the postfix stack evaluator
// no dependencies
`timescale 1ns / 1ps

package pse_pkg;

  localparam int StackDepth = 16;
  localparam int DataW      = 32;
  localparam int KindW      = 3;
  localparam int StatusW    = 3;
  localparam int FracW      = 16;
  localparam int DivW       = DataW + FracW;
  localparam int ProdW      = 2 * DataW;

  typedef enum logic [KindW-1:0] {
    KindNum = 3'd0,
    KindAdd = 3'd1,
    KindSub = 3'd2,
    KindMul = 3'd3,
    KindDiv = 3'd4,
    KindEnd = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 3'd0,
    StUnder = 3'd1,
    StFull  = 3'd2,
    StDivz  = 3'd3,
    StSat   = 3'd4
  } status_e;

  // per-cell shift control
  typedef struct packed {
    logic shift_dn;  // take the entry from the cell above (push)
    logic shift_up;  // take the entry from the cell below (pop)
  } cell_ctrl_t;

endpackage

// File: design/postfix_stack_evaluator_top.sv
// top level of the postfix stack evaluator: stack of shifting cells plus arithmetic
// depends on pse_pkg, pse_cell and pse_div
`timescale 1ns / 1ps

// postfix (rpn) evaluator on a stack of signed q16.16 values
//
// input channel s_axis: one token per transfer, tuser = kind, tdata = value
//   kinds: number pushes value, add/sub/mul/div pop top t and second s and push
//   t op s, end reports the top and empties the stack
// output channel m_axis: exactly one result per token, tdata = top of stack after
//   the token, tuser = status, tlast = result of an end token
//
// path from input transfer to output valid:
//   number, add, subtract, end, bad kind, errors : straight into the output register
//   multiply : product register, then shift and clamp
//   divide   : bit-serial divider (48 quotient bits), then sign and clamp
// one token is in work at a time; a multiply or divide token holds the input until its
// result is registered (other tokens: one per cycle while the output drains), and a token
// is taken only when the output register is empty or being drained in the same cycle
//
// the stack is a row of cells with the top in cell 0; a push shifts every cell
// down one place, an operator shifts the cells below the top up one place
// reset clears the entry count and the handshake state; cell contents are don't care
// a stalled receiver holds the result in the output register and blocks new tokens

module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = pse_pkg::StackDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // token input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pse_pkg::DataW-1:0]    s_axis_tdata,   // [31:0] value
  input  logic [pse_pkg::KindW-1:0]    s_axis_tuser,   // [2:0] kind
  // result output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pse_pkg::DataW-1:0]    m_axis_tdata,   // [31:0] top_value
  output logic [pse_pkg::StatusW-1:0]  m_axis_tuser,   // [2:0] status
  output logic                         m_axis_tlast    // final_res
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int DW   = pse_pkg::DataW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_vld_q, out_vld_d;
  logic [DW-1:0]          out_top_q, out_top_d;
  pse_pkg::status_e       status_q, status_d;
  logic                   last_q, last_d;
  logic                   neg_q, neg_d;
  logic signed [pse_pkg::ProdW-1:0] prod_q;

  // cell row
  logic [DW-1:0]          cell_data [STACK_DEPTH];
  pse_pkg::cell_ctrl_t    cell_ctrl [STACK_DEPTH];
  logic                   push, op_wr;
  logic [DW-1:0]          wr_data;

  // handshake helpers
  logic                   in_acc, slot_free;
  pse_pkg::kind_e         kind;
  logic [DW-1:0]          top_cur;
  logic                   full, under;

  // add / subtract
  logic [DW:0]            sum_add, sum_sub;
  logic                   sat_add, sat_sub;
  logic [DW-1:0]          res_add, res_sub;

  // multiply post-processing
  logic [pse_pkg::DivW-1:0] mul_sh;
  logic                   sat_mul;
  logic [DW-1:0]          res_mul;

  // divide
  logic                   div_start, div_done;
  logic [DW-1:0]          abs_t, abs_s;
  logic [pse_pkg::DivW-1:0] quot;
  logic                   sat_div;
  logic [DW-1:0]          res_div;

  assign kind      = pse_pkg::kind_e'(s_axis_tuser);
  assign slot_free = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign top_cur = (cnt_q == '0) ? '0 : cell_data[0];
  assign full    = (cnt_q == CntW'(STACK_DEPTH));
  assign under   = (cnt_q < CntW'(2));

  // t + s and t - s with clamp to 32 bits
  assign sum_add = {cell_data[0][DW-1], cell_data[0]} + {cell_data[1][DW-1], cell_data[1]};
  assign sum_sub = {cell_data[0][DW-1], cell_data[0]} - {cell_data[1][DW-1], cell_data[1]};
  assign sat_add = sum_add[DW] ^ sum_add[DW-1];
  assign sat_sub = sum_sub[DW] ^ sum_sub[DW-1];
  assign res_add = sat_add ? {sum_add[DW], {(DW-1){!sum_add[DW]}}} : sum_add[DW-1:0];
  assign res_sub = sat_sub ? {sum_sub[DW], {(DW-1){!sum_sub[DW]}}} : sum_sub[DW-1:0];

  // product shifted right by the fraction width rounds toward minus infinity
  assign mul_sh  = prod_q[pse_pkg::ProdW-1:pse_pkg::FracW];
  assign sat_mul = !((&mul_sh[pse_pkg::DivW-1:DW-1]) || !(|mul_sh[pse_pkg::DivW-1:DW-1]));
  assign res_mul = sat_mul ? {mul_sh[pse_pkg::DivW-1], {(DW-1){!mul_sh[pse_pkg::DivW-1]}}}
                           : mul_sh[DW-1:0];

  // divide on magnitudes, sign applied afterwards (truncation toward zero)
  assign abs_t = cell_data[0][DW-1] ? (~cell_data[0] + 1'b1) : cell_data[0];
  assign abs_s = cell_data[1][DW-1] ? (~cell_data[1] + 1'b1) : cell_data[1];

  always_comb begin
    if (neg_q) begin
      sat_div = (|quot[pse_pkg::DivW-1:DW]) || (quot[DW-1] && (|quot[DW-2:0]));
      res_div = sat_div ? {1'b1, {(DW-1){1'b0}}} : (~quot[DW-1:0] + 1'b1);
    end else begin
      sat_div = |quot[pse_pkg::DivW-1:DW-1];
      res_div = sat_div ? {1'b0, {(DW-1){1'b1}}} : quot[DW-1:0];
    end
  end

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({abs_t, {pse_pkg::FracW{1'b0}}}),
    .divisor_i  (abs_s),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // token sequencing
  always_comb begin
    logic emit;
    emit      = 1'b0;
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_top_d = out_top_q;
    status_d  = status_q;
    last_d    = last_q;
    neg_d     = neg_q;
    push      = 1'b0;
    op_wr     = 1'b0;
    wr_data   = s_axis_tdata;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          emit      = 1'b1;
          out_top_d = top_cur;
          status_d  = pse_pkg::StOk;
          last_d    = 1'b0;
          case (kind)
            pse_pkg::KindNum: begin
              if (full) begin
                status_d = pse_pkg::StFull;
              end else begin
                push      = 1'b1;
                cnt_d     = cnt_q + 1'b1;
                out_top_d = s_axis_tdata;
              end
            end
            pse_pkg::KindAdd, pse_pkg::KindSub: begin
              if (under) begin
                status_d = pse_pkg::StUnder;
              end else begin
                op_wr     = 1'b1;
                cnt_d     = cnt_q - 1'b1;
                wr_data   = (kind == pse_pkg::KindAdd) ? res_add : res_sub;
                out_top_d = wr_data;
                if ((kind == pse_pkg::KindAdd) ? sat_add : sat_sub) begin
                  status_d = pse_pkg::StSat;
                end
              end
            end
            pse_pkg::KindMul: begin
              if (under) begin
                status_d = pse_pkg::StUnder;
              end else begin
                emit    = 1'b0;
                state_d = ST_MUL;
              end
            end
            pse_pkg::KindDiv: begin
              if (under) begin
                status_d = pse_pkg::StUnder;
              end else if (cell_data[1] == '0) begin
                status_d = pse_pkg::StDivz;
              end else begin
                emit      = 1'b0;
                div_start = 1'b1;
                neg_d     = cell_data[0][DW-1] ^ cell_data[1][DW-1];
                state_d   = ST_DIV;
              end
            end
            pse_pkg::KindEnd: begin
              last_d = 1'b1;
              if (cnt_q == '0) begin
                status_d = pse_pkg::StUnder;
              end
              cnt_d = '0;
            end
            default: begin
              // unused kind codes leave the stack alone
            end
          endcase
        end
      end
      ST_MUL: begin
        if (slot_free) begin
          emit      = 1'b1;
          op_wr     = 1'b1;
          cnt_d     = cnt_q - 1'b1;
          wr_data   = res_mul;
          out_top_d = res_mul;
          status_d  = sat_mul ? pse_pkg::StSat : pse_pkg::StOk;
          last_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done && slot_free) begin
          emit      = 1'b1;
          op_wr     = 1'b1;
          cnt_d     = cnt_q - 1'b1;
          wr_data   = res_div;
          out_top_d = res_div;
          status_d  = sat_div ? pse_pkg::StSat : pse_pkg::StOk;
          last_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      out_top_q <= '0;
      status_q  <= pse_pkg::StOk;
      last_q    <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      out_top_q <= out_top_d;
      status_q  <= status_d;
      last_q    <= last_d;
      neg_q     <= neg_d;
    end
  end

  // full product of top and second entry, registered before the shift and clamp
  always_ff @(posedge clk_i) begin
    if (in_acc && (kind == pse_pkg::KindMul)) begin
      prod_q <= $signed(cell_data[0]) * $signed(cell_data[1]);
    end
  end

  // row of stack cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DW-1:0] prev_data, next_data;

    if (i == 0) begin : g_top
      assign prev_data        = wr_data;
      assign cell_ctrl[i].shift_dn = push || op_wr;
      assign cell_ctrl[i].shift_up = 1'b0;
    end else begin : g_low
      assign prev_data        = cell_data[i-1];
      assign cell_ctrl[i].shift_dn = push;
      assign cell_ctrl[i].shift_up = op_wr;
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    pse_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .prev_i (prev_data),
      .next_i (next_data),
      .data_o (cell_data[i])
    );
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_top_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

endmodule

// File: design/pse_cell.sv
// one stack cell: holds a single q16.16 entry and shifts with its neighbors
// depends on pse_pkg
`timescale 1ns / 1ps

module pse_cell (
  input  logic                       clk_i,
  input  pse_pkg::cell_ctrl_t        ctrl_i,
  input  logic [pse_pkg::DataW-1:0]  prev_i,
  input  logic [pse_pkg::DataW-1:0]  next_i,
  output logic [pse_pkg::DataW-1:0]  data_o
);

  logic [pse_pkg::DataW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_dn) begin
      data_q <= prev_i;
    end else if (ctrl_i.shift_up) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

// File: design/pse_div.sv
// restoring divider on magnitudes, one quotient bit per cycle
// depends on pse_pkg
`timescale 1ns / 1ps

module pse_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pse_pkg::DivW-1:0]  dividend_i,
  input  logic [pse_pkg::DataW-1:0] divisor_i,
  output logic [pse_pkg::DivW-1:0]  quot_o,
  output logic                      done_o
);

  localparam int CntW = $clog2(pse_pkg::DivW);

  logic [pse_pkg::DataW-1:0] rem_q, rem_d;
  logic [pse_pkg::DivW-1:0]  quo_q, quo_d;
  logic [pse_pkg::DataW-1:0] dvs_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q, done_q;
  logic [pse_pkg::DataW:0]   rem_sh;
  logic [pse_pkg::DataW+1:0] diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[pse_pkg::DivW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    if (!diff[pse_pkg::DataW+1]) begin
      rem_d = diff[pse_pkg::DataW-1:0];
      quo_d = {quo_q[pse_pkg::DivW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[pse_pkg::DataW-1:0];
      quo_d = {quo_q[pse_pkg::DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(pse_pkg::DivW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// File: design/pse_chk.sv
// port-level checker of the postfix stack evaluator, bound to the top level
// depends on pse_pkg and postfix_stack_evaluator_top_macros.svh
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_top_macros.svh"

module pse_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pse_pkg::DataW-1:0]    m_axis_tdata,
  input logic [pse_pkg::StatusW-1:0]  m_axis_tuser,
  input logic                         m_axis_tlast
);

  logic out_stall;
  logic end_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign end_ok    = (m_axis_tuser == pse_pkg::StOk) || (m_axis_tuser == pse_pkg::StUnder);

  // a stalled result blocks the next token
  `PSE_ASSERT(a_no_take_on_stall, out_stall |-> !s_axis_tready, "token taken while stalled")

  // an end result only reports ok or underflow
  `PSE_ASSERT(a_end_status, (m_axis_tvalid && m_axis_tlast) |-> end_ok, "bad end status")

  `PSE_ASSERT_HOLD(a_vld_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid, "tvalid not held")

  `PSE_ASSERT_HOLD(a_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "tdata not held")

endmodule

bind postfix_stack_evaluator_top pse_chk u_pse_chk (.*);
